// ===== design/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared constants, types and helpers for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int unsigned CHANNEL_BITS_DEF  = 8;
  localparam int unsigned SAT_FRAC_BITS_DEF = 12;

  // hue quotient after the 60 degree offset lies in 0..120
  localparam int unsigned HUE_Q_BITS  = 7;
  localparam int unsigned HUE_SCALE   = 120;
  localparam int unsigned HUE_FULL    = 360;
  localparam int unsigned HUE_SUM_BITS = 10;
  localparam int unsigned HUE_BASE_RED   = 300;
  localparam int unsigned HUE_BASE_GREEN = 420;
  localparam int unsigned HUE_BASE_BLUE  = 540;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } hue_sector_t;

  // number of divider cells: enough quotient bits for both divisions
  function automatic int unsigned chain_len(input int unsigned frac_bits);
    int unsigned n;
    n = frac_bits + 1;
    if (n < HUE_Q_BITS) begin
      n = HUE_Q_BITS;
    end
    return n;
  endfunction

endpackage

// ===== design/rgbhsl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_if
// Valid/ready channels for RGB pixels in and HSL results out.
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if #(
  parameter int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if #(
  parameter int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned F  = rgbhsl_pkg::SAT_FRAC_BITS_DEF
) ();
  logic        valid;
  logic        ready;
  logic [8:0]  hue_degrees;
  logic [F:0]  saturation_frac;
  logic [CB:0] luminance_sum;

  modport source (output valid, output hue_degrees, output saturation_frac,
                  output luminance_sum, input ready);
  modport sink   (input valid, input hue_degrees, input saturation_frac,
                  input luminance_sum, output ready);
endinterface

// ===== design/rgbhsl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_front
// Max/min, sector select and dividend/divisor set-up, registered.
// ----------------------------------------------------------------------------
module rgbhsl_front #(
  parameter int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned F  = rgbhsl_pkg::SAT_FRAC_BITS_DEF,
  parameter int unsigned HW = CB + 8,
  parameter int unsigned SW = CB + F + 2,
  parameter int unsigned DW = CB + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  rgbhsl_pix_if.sink              pix,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [HW-1:0]           hue_rem_o,
  output logic [DW-1:0]           hue_div_o,
  output logic [SW-1:0]           sat_rem_o,
  output logic [DW-1:0]           sat_div_o,
  output logic                    grey_o,
  output rgbhsl_pkg::hue_sector_t sector_o,
  output logic [CB:0]             lum_o
);

  logic                    valid_r;
  logic [HW-1:0]           hue_rem_r;
  logic [DW-1:0]           hue_div_r;
  logic [SW-1:0]           sat_rem_r;
  logic [DW-1:0]           sat_div_r;
  logic                    grey_r;
  rgbhsl_pkg::hue_sector_t sector_r;
  logic [CB:0]             lum_r;

  rgbhsl_pkg::hue_sector_t sector_nxt;
  logic [CB-1:0] mx, mn, pos, neg, d;
  logic [CB:0]   sum, den, t;
  logic [CB+1:0] t_wide;
  logic [CB:0]   chan_max2;

  assign pix.ready = !valid_r || ready_i;

  always_comb begin
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sector_nxt = rgbhsl_pkg::SECT_RED;
    end else if (pix.green >= pix.blue) begin
      sector_nxt = rgbhsl_pkg::SECT_GREEN;
    end else begin
      sector_nxt = rgbhsl_pkg::SECT_BLUE;
    end
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    case (sector_nxt)
      rgbhsl_pkg::SECT_RED: begin
        mx = pix.red;   pos = pix.green; neg = pix.blue;
      end
      rgbhsl_pkg::SECT_GREEN: begin
        mx = pix.green; pos = pix.blue;  neg = pix.red;
      end
      default: begin
        mx = pix.blue;  pos = pix.red;   neg = pix.green;
      end
    endcase
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    // pos - neg + d, always within 0..2d
    t_wide = (CB+2)'(pos) + (CB+2)'(mx) - (CB+2)'(neg) - (CB+2)'(mn);
    t      = t_wide[CB:0];
    chan_max2 = {{CB{1'b1}}, 1'b0};
    den = (sum <= {1'b0, {CB{1'b1}}}) ? sum : chan_max2 - sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pix.ready) begin
      valid_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      hue_rem_r <= HW'(t) * HW'(rgbhsl_pkg::HUE_SCALE) + HW'(d);
      hue_div_r <= {d, 1'b0};
      sat_rem_r <= (SW'(d) << (F + 1)) + SW'(den);
      sat_div_r <= {den[CB-1:0], 1'b0};
      grey_r    <= (d == '0);
      sector_r  <= sector_nxt;
      lum_r     <= sum;
    end
  end

  assign valid_o   = valid_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign grey_o    = grey_r;
  assign sector_o  = sector_r;
  assign lum_o     = lum_r;

endmodule

// ===== design/rgbhsl_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div_cell
// One restoring-division step for hue and saturation, with its own register.
// ----------------------------------------------------------------------------
module rgbhsl_div_cell #(
  parameter int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned HW = CB + 8,
  parameter int unsigned SW = CB + 14,
  parameter int unsigned DW = CB + 1,
  parameter int unsigned L  = rgbhsl_pkg::HUE_Q_BITS,
  parameter int unsigned K  = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  input  logic [HW-1:0]           hue_rem_i,
  input  logic [DW-1:0]           hue_div_i,
  input  logic [L-1:0]            hue_q_i,
  input  logic [SW-1:0]           sat_rem_i,
  input  logic [DW-1:0]           sat_div_i,
  input  logic [L-1:0]            sat_q_i,
  input  logic                    grey_i,
  input  rgbhsl_pkg::hue_sector_t sector_i,
  input  logic [CB:0]             lum_i,
  output logic [HW-1:0]           hue_rem_o,
  output logic [DW-1:0]           hue_div_o,
  output logic [L-1:0]            hue_q_o,
  output logic [SW-1:0]           sat_rem_o,
  output logic [DW-1:0]           sat_div_o,
  output logic [L-1:0]            sat_q_o,
  output logic                    grey_o,
  output rgbhsl_pkg::hue_sector_t sector_o,
  output logic [CB:0]             lum_o
);

  localparam int unsigned HEW = HW + DW + L;
  localparam int unsigned SEW = SW + DW + L;

  logic                    valid_r;
  logic [HW-1:0]           hue_rem_r, hue_rem_nxt;
  logic [DW-1:0]           hue_div_r;
  logic [L-1:0]            hue_q_r, hue_q_nxt;
  logic [SW-1:0]           sat_rem_r, sat_rem_nxt;
  logic [DW-1:0]           sat_div_r;
  logic [L-1:0]            sat_q_r, sat_q_nxt;
  logic                    grey_r;
  rgbhsl_pkg::hue_sector_t sector_r;
  logic [CB:0]             lum_r;

  logic [HEW-1:0] h_shift, h_ext;
  logic [SEW-1:0] s_shift, s_ext;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    h_ext   = HEW'(hue_rem_i);
    h_shift = HEW'(hue_div_i) << K;
    s_ext   = SEW'(sat_rem_i);
    s_shift = SEW'(sat_div_i) << K;
    hue_rem_nxt = hue_rem_i;
    hue_q_nxt   = hue_q_i;
    sat_rem_nxt = sat_rem_i;
    sat_q_nxt   = sat_q_i;
    if (h_ext >= h_shift) begin
      hue_rem_nxt = HW'(h_ext - h_shift);
      hue_q_nxt   = hue_q_i | (L'(1) << K);
    end
    if (s_ext >= s_shift) begin
      sat_rem_nxt = SW'(s_ext - s_shift);
      sat_q_nxt   = sat_q_i | (L'(1) << K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      hue_rem_r <= hue_rem_nxt;
      hue_div_r <= hue_div_i;
      hue_q_r   <= hue_q_nxt;
      sat_rem_r <= sat_rem_nxt;
      sat_div_r <= sat_div_i;
      sat_q_r   <= sat_q_nxt;
      grey_r    <= grey_i;
      sector_r  <= sector_i;
      lum_r     <= lum_i;
    end
  end

  assign valid_o   = valid_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign hue_q_o   = hue_q_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign sat_q_o   = sat_q_r;
  assign grey_o    = grey_r;
  assign sector_o  = sector_r;
  assign lum_o     = lum_r;

endmodule

// ===== design/rgbhsl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_back
// Hue base add and wrap, grey override, output register.
// ----------------------------------------------------------------------------
module rgbhsl_back #(
  parameter int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned F  = rgbhsl_pkg::SAT_FRAC_BITS_DEF,
  parameter int unsigned L  = rgbhsl_pkg::HUE_Q_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [L-1:0]            hue_q_i,
  input  logic [L-1:0]            sat_q_i,
  input  logic                    grey_i,
  input  rgbhsl_pkg::hue_sector_t sector_i,
  input  logic [CB:0]             lum_i,
  rgbhsl_hsl_if.source            res
);

  localparam int unsigned HS = rgbhsl_pkg::HUE_SUM_BITS;

  logic        valid_r;
  logic [8:0]  hue_r, hue_nxt;
  logic [F:0]  sat_r, sat_nxt;
  logic [CB:0] lum_r;
  logic [HS-1:0] base, hsum;

  assign ready_o = !valid_r || res.ready;

  always_comb begin
    case (sector_i)
      rgbhsl_pkg::SECT_RED:   base = HS'(rgbhsl_pkg::HUE_BASE_RED);
      rgbhsl_pkg::SECT_GREEN: base = HS'(rgbhsl_pkg::HUE_BASE_GREEN);
      default:                base = HS'(rgbhsl_pkg::HUE_BASE_BLUE);
    endcase
    hsum = base + HS'(hue_q_i[rgbhsl_pkg::HUE_Q_BITS-1:0]);
    // sum is below 720, one wrap is enough
    if (hsum >= HS'(rgbhsl_pkg::HUE_FULL)) begin
      hsum = hsum - HS'(rgbhsl_pkg::HUE_FULL);
    end
    hue_nxt = grey_i ? '0 : hsum[8:0];
    sat_nxt = grey_i ? '0 : sat_q_i[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lum_r <= lum_i;
    end
  end

  assign res.valid           = valid_r;
  assign res.hue_degrees     = hue_r;
  assign res.saturation_frac = sat_r;
  assign res.luminance_sum   = lum_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (hue_r < 9'(rgbhsl_pkg::HUE_FULL)))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (sat_r <= ((F+1)'(1) << F)))
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && lum_r == '0) |-> (sat_r == '0 && hue_r == '0))
    else $error("black pixel with colour");

  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && lum_r == {{CB{1'b1}}, 1'b0}) |-> (sat_r == '0 && hue_r == '0))
    else $error("white pixel with colour");

endmodule

// ===== design/rgb_to_hsl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl
// Pipelined RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries one RGB pixel per transfer (valid/ready). out_hsl returns
//   hue in whole degrees (0..359), saturation as a fraction of
//   2^SAT_FRAC_BITS and max+min as luminance, one result per pixel, in order.
//   A set-up register computes max, min and the two dividends, then a row of
//   L = max(7, SAT_FRAC_BITS+1) division cells produces one quotient bit of
//   both hue and saturation each, then an output register adds the hue base
//   and wraps at 360.
//   The path runs through L + 2 register stages. Throughput: one pixel per
//   cycle while out_hsl.ready stays high; the cell row sets the depth.
//   Each stage has its own ready, so bubbles are squeezed out while the
//   receiver stalls and the row keeps filling until every stage holds a
//   pixel; then in_pix.ready drops.
//   Reset (rst_n low, synchronous) empties every stage; pixels in flight
//   are dropped and none is kept after it.
// ----------------------------------------------------------------------------
module rgb_to_hsl #(
  parameter int unsigned CHANNEL_BITS  = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned SAT_FRAC_BITS = rgbhsl_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rgbhsl_pix_if.sink   in_pix,
  rgbhsl_hsl_if.source out_hsl
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned F  = SAT_FRAC_BITS;
  localparam int unsigned HW = CB + 8;
  localparam int unsigned SW = CB + F + 2;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned L  = rgbhsl_pkg::chain_len(F);

  logic                    c_valid  [0:L];
  logic                    c_ready  [0:L];
  logic [HW-1:0]           c_hrem   [0:L];
  logic [DW-1:0]           c_hdiv   [0:L];
  logic [L-1:0]            c_hq     [0:L];
  logic [SW-1:0]           c_srem   [0:L];
  logic [DW-1:0]           c_sdiv   [0:L];
  logic [L-1:0]            c_sq     [0:L];
  logic                    c_grey   [0:L];
  rgbhsl_pkg::hue_sector_t c_sector [0:L];
  logic [CB:0]             c_lum    [0:L];

  assign c_hq[0] = '0;
  assign c_sq[0] = '0;

  rgbhsl_front #(.CB(CB), .F(F), .HW(HW), .SW(SW), .DW(DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .valid_o   (c_valid[0]),
    .ready_i   (c_ready[0]),
    .hue_rem_o (c_hrem[0]),
    .hue_div_o (c_hdiv[0]),
    .sat_rem_o (c_srem[0]),
    .sat_div_o (c_sdiv[0]),
    .grey_o    (c_grey[0]),
    .sector_o  (c_sector[0]),
    .lum_o     (c_lum[0])
  );

  for (genvar i = 0; i < L; i++) begin : g_cell
    rgbhsl_div_cell #(
      .CB(CB), .HW(HW), .SW(SW), .DW(DW), .L(L), .K(L - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_i   (c_valid[i]),
      .ready_o   (c_ready[i]),
      .valid_o   (c_valid[i+1]),
      .ready_i   (c_ready[i+1]),
      .hue_rem_i (c_hrem[i]),
      .hue_div_i (c_hdiv[i]),
      .hue_q_i   (c_hq[i]),
      .sat_rem_i (c_srem[i]),
      .sat_div_i (c_sdiv[i]),
      .sat_q_i   (c_sq[i]),
      .grey_i    (c_grey[i]),
      .sector_i  (c_sector[i]),
      .lum_i     (c_lum[i]),
      .hue_rem_o (c_hrem[i+1]),
      .hue_div_o (c_hdiv[i+1]),
      .hue_q_o   (c_hq[i+1]),
      .sat_rem_o (c_srem[i+1]),
      .sat_div_o (c_sdiv[i+1]),
      .sat_q_o   (c_sq[i+1]),
      .grey_o    (c_grey[i+1]),
      .sector_o  (c_sector[i+1]),
      .lum_o     (c_lum[i+1])
    );
  end

  rgbhsl_back #(.CB(CB), .F(F), .L(L)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (c_valid[L]),
    .ready_o  (c_ready[L]),
    .hue_q_i  (c_hq[L]),
    .sat_q_i  (c_sq[L]),
    .grey_i   (c_grey[L]),
    .sector_i (c_sector[L]),
    .lum_i    (c_lum[L]),
    .res      (out_hsl)
  );

endmodule

// ===== sim/rgb_to_hsl_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_tb
// Streams RGB pixels through the converter and checks hue, saturation and
// luminance of every result against a bit-exact integer predictor, under
// several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module rgb_to_hsl_tb;

  localparam int unsigned CB = rgbhsl_pkg::CHANNEL_BITS_DEF;
  localparam int unsigned FB = rgbhsl_pkg::SAT_FRAC_BITS_DEF;
  localparam int unsigned N_RAND = 1400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct packed {
    logic [8:0]  hue;
    logic [FB:0] sat;
    logic [CB:0] lum;
  } hsl_t;

  typedef struct {
    logic [CB-1:0] r, g, b;
    bit            has_exp;
    hsl_t          exp_val;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgbhsl_pix_if #(.CB(CB)) pix ();
  rgbhsl_hsl_if #(.CB(CB), .F(FB)) hsl ();

  rgb_to_hsl dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix.sink),
    .out_hsl(hsl.source)
  );

  always #6 clk = ~clk;

  hsl_t        hsl_expected[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_off = 1'b0;

  // integer form of the conversion; hue offset by 360 to keep it positive
  function automatic hsl_t convert_pixel(logic [CB-1:0] r, logic [CB-1:0] g,
                                         logic [CB-1:0] b);
    hsl_t        res;
    longint      mx, mn, d, sum, den, base, pos, neg, n, q;
    longint      cmax;
    cmax = (1 << CB) - 1;
    mx = longint'(r); if (g > mx) mx = longint'(g); if (b > mx) mx = longint'(b);
    mn = longint'(r); if (g < mn) mn = longint'(g); if (b < mn) mn = longint'(b);
    d = mx - mn;
    sum = mx + mn;
    res.lum = sum[CB:0];
    res.hue = '0;
    res.sat = '0;
    if (d != 0) begin
      if (longint'(r) == mx) begin
        base = 0; pos = longint'(g); neg = longint'(b);
      end else if (longint'(g) == mx) begin
        base = 120; pos = longint'(b); neg = longint'(r);
      end else begin
        base = 240; pos = longint'(r); neg = longint'(g);
      end
      n = (360 + base) * d + 60 * (pos - neg);
      q = (2 * n + d) / (2 * d);
      res.hue = 9'(q % 360);
      den = (sum <= cmax) ? sum : (2 * cmax - sum);
      res.sat = (FB + 1)'(((d << (FB + 1)) + den) / (2 * den));
    end
    return res;
  endfunction

  task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    hsl_expected.push_back(convert_pixel(r, g, b));
    do @(posedge clk); while (!pix.ready);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hsl.ready <= 1'b0;
    end else begin
      hsl.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    hsl_t got, want;
    if (rst_n && hsl.valid && hsl.ready) begin
      got = '{hsl.hue_degrees, hsl.saturation_frac, hsl.luminance_sum};
      n_results++;
      if (hsl_expected.size() == 0) begin
        $display("%0t: unexpected result hue=%0d sat=%0d lum=%0d", $time,
                 got.hue, got.sat, got.lum);
        n_errors++;
      end else begin
        want = hsl_expected.pop_front();
        if (got.hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
          n_errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: sat expected %0d actual %0d", $time, want.sat, got.sat);
          n_errors++;
        end
        if (got.lum !== want.lum) begin
          $display("%0t: lum expected %0d actual %0d", $time, want.lum, got.lum);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles,
               hsl_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic pix_row_t row(int r, int g, int b, bit he, int h, int s, int l);
    pix_row_t x;
    x.r = CB'(r); x.g = CB'(g); x.b = CB'(b); x.has_exp = he;
    x.exp_val = '{9'(h), (FB + 1)'(s), (CB + 1)'(l)};
    return x;
  endfunction

  initial begin
    pix_row_t      tbl[$];
    int unsigned   phase, k;
    logic [CB-1:0] r, g, b, lo, hi;

    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;

    // directed rows: greys, primaries, ties, extremes of each branch
    tbl.push_back(row(0, 0, 0, 1, 0, 0, 0));
    tbl.push_back(row(255, 255, 255, 1, 0, 0, 510));
    tbl.push_back(row(128, 128, 128, 1, 0, 0, 256));
    tbl.push_back(row(255, 0, 0, 1, 0, 4096, 255));
    tbl.push_back(row(0, 255, 0, 1, 120, 4096, 255));
    tbl.push_back(row(0, 0, 255, 1, 240, 4096, 255));
    tbl.push_back(row(255, 255, 0, 1, 60, 4096, 255));
    tbl.push_back(row(0, 255, 255, 1, 180, 4096, 255));
    tbl.push_back(row(255, 0, 255, 1, 300, 4096, 255));
    tbl.push_back(row(1, 0, 0, 1, 0, 4096, 1));
    tbl.push_back(row(255, 254, 254, 1, 0, 4096, 509));
    tbl.push_back(row(255, 0, 1, 0, 0, 0, 0));
    tbl.push_back(row(255, 1, 0, 0, 0, 0, 0));
    tbl.push_back(row(0, 1, 1, 0, 0, 0, 0));
    tbl.push_back(row(128, 127, 0, 0, 0, 0, 0));
    tbl.push_back(row(127, 128, 0, 0, 0, 0, 0));
    tbl.push_back(row(170, 85, 200, 0, 0, 0, 0));
    tbl.push_back(row(200, 100, 50, 0, 0, 0, 0));
    tbl.push_back(row(128, 127, 127, 0, 0, 0, 0));
    tbl.push_back(row(127, 128, 127, 0, 0, 0, 0));
    tbl.push_back(row(85, 170, 170, 0, 0, 0, 0));
    tbl.push_back(row(3, 255, 4, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tbl[i]) begin
      if (tbl[i].has_exp &&
          convert_pixel(tbl[i].r, tbl[i].g, tbl[i].b) !== tbl[i].exp_val) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i,
                 tbl[i].exp_val, convert_pixel(tbl[i].r, tbl[i].g, tbl[i].b));
        n_errors++;
      end
      send_pixel(tbl[i].r, tbl[i].g, tbl[i].b);
    end

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
        3: begin src_idle_pct = 14; snk_stall_pct = 14; end
        default: begin src_idle_pct = 0; snk_stall_pct = 0; end
      endcase
      if (phase == 4) begin
        // long hold-off in its own process: the pipeline fills and the
        // input stalls while the sender keeps offering pixels
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (k = 0; k < N_RAND / 5; k++) begin
        // mix of near-grey, tie-heavy and fully random pixels
        case ($urandom_range(3))
          0: begin
            lo = CB'($urandom); hi = CB'(lo + $urandom_range(3));
            r = $urandom_range(1) ? lo : hi;
            g = $urandom_range(1) ? lo : hi;
            b = $urandom_range(1) ? lo : hi;
          end
          1: begin
            r = $urandom_range(1) ? 8'd0 : 8'd255;
            g = CB'($urandom); b = $urandom_range(1) ? r : g;
          end
          default: begin r = CB'($urandom); g = CB'($urandom); b = CB'($urandom); end
        endcase
        send_pixel(r, g, b);
      end
    end
    pix.valid <= 1'b0;

    while (hsl_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Converted %0d pixels: greys, primaries, ties, extremes and random mixes,",
             n_results);
    $display("with source idling, sink stalls and a long output hold-off.");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rgbhsl_pkg.sv
design/rgbhsl_if.sv
design/rgbhsl_front.sv
design/rgbhsl_div_cell.sv
design/rgbhsl_back.sv
design/rgb_to_hsl.sv
sim/rgb_to_hsl_tb.sv
